// ===== design/mavg_pkg.sv =====
package mavg_pkg;

   // Fixed widths of the block's fields and registers
   localparam int DATA_BITS     = 32;
   localparam int SUM_BITS      = 40;
   localparam int LEN_BITS      = 9;
   localparam int CSR_ADDR_BITS = 4;

   // Defaults for the top-level parameters
   localparam int WINDOW_MAX_DEFAULT  = 256;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   // Divider: quotient bits resolved per cycle, and cycles per division
   localparam int DIV_STEPS    = 4;
   localparam int DIV_CYCLES   = SUM_BITS / DIV_STEPS;
   localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Register indexes, taken from paddr[3:2]
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_WINDOW_LENGTH   = 2'd0;
   localparam reg_index_type REG_INITIAL_VALUE   = 2'd1;
   localparam reg_index_type REG_FILL_WITH_FIRST = 2'd2;

   typedef enum logic {
      FR_IDLE,
      FR_UPDATE
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_FINISH
   } back_state_type;

   // One updated window sum, waiting for its division
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [LEN_BITS-1:0]        len;
   } entry_type;

endpackage

// ===== design/mavg_front.sv =====
module mavg_front #(
   parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [mavg_pkg::DATA_BITS-1:0]     req_sample,
   input  logic [mavg_pkg::LEN_BITS-1:0]      window_length,
   input  logic [mavg_pkg::DATA_BITS-1:0]     initial_value,
   input  logic                               fill_with_first,
   output mavg_pkg::entry_type                q_entry,
   output logic                               q_push,
   input  logic                               q_full
);
   import mavg_pkg::*;

   localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_CAP = (WINDOW_MAX < (1 << LEN_BITS) - 1) ? WINDOW_MAX
                                                                : (1 << LEN_BITS) - 1;
   localparam int CW      = (AW + 1 > LEN_BITS) ? AW + 1 : LEN_BITS;
   localparam int PW      = SAMPLE_BITS + LEN_BITS + 1;

   front_state_type state_ff, state_in;

   logic                          primed_ff, primed_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [AW:0]                   hwm_ff, hwm_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] fill_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [LEN_BITS-1:0]           len_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;

   logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];

   logic                          accept;
   logic                          wr_en;
   logic [LEN_BITS-1:0]           len_eff;
   logic signed [SAMPLE_BITS-1:0] s_new;
   logic signed [SAMPLE_BITS-1:0] init_ext;
   logic signed [SAMPLE_BITS-1:0] fill_new;
   logic signed [PW-1:0]          fill_wide;
   logic signed [PW-1:0]          len_wide;
   logic signed [PW-1:0]          prod;
   logic signed [SAMPLE_BITS-1:0] old_val;
   logic signed [SUM_BITS-1:0]    sum_upd;
   logic [AW:0]                   pos_inc;

   // Effective length: zero acts as one, clamp to store depth
   always_comb begin
      if (window_length == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (window_length > LEN_BITS'(LEN_CAP)) begin
         len_eff = LEN_BITS'(LEN_CAP);
      end else begin
         len_eff = window_length;
      end
   end

   assign s_new     = signed'(req_sample[SAMPLE_BITS-1:0]);
   assign init_ext  = signed'(initial_value[SAMPLE_BITS-1:0]);
   assign fill_new  = fill_with_first ? s_new : init_ext;
   assign fill_wide = PW'(fill_new);
   assign len_wide  = signed'(PW'(len_eff));
   assign prod      = fill_wide * len_wide;

   // Entries at or above the high-water mark still hold the fill value
   assign old_val = ({1'b0, pos_ff} < hwm_ff) ? old_ff : fill_ff;
   assign sum_upd = sum_ff - SUM_BITS'(old_val) + SUM_BITS'(sample_ff);
   assign pos_inc = {1'b0, pos_ff} + (AW + 1)'(1);

   // Next state
   always_comb begin
      case (state_ff)
         FR_IDLE:   state_in = push ? FR_UPDATE : FR_IDLE;
         FR_UPDATE: state_in = q_full ? FR_UPDATE : FR_IDLE;
         default:   state_in = FR_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      full   = 1'b1;
      q_push = 1'b0;
      case (state_ff)
         FR_IDLE:   full = 1'b0;
         FR_UPDATE: q_push = !q_full;
         default:   full = 1'b1;
      endcase
   end

   assign accept = push && !full;
   assign wr_en  = q_push;

   assign q_entry.sum = sum_upd;
   assign q_entry.len = len_ff;

   // Window bookkeeping
   always_comb begin
      primed_in = primed_ff;
      pos_in    = pos_ff;
      hwm_in    = hwm_ff;
      sum_in    = sum_ff;
      if (accept && !primed_ff) begin
         primed_in = 1'b1;
         pos_in    = '0;
         hwm_in    = '0;
         sum_in    = SUM_BITS'(prod);
      end
      if (wr_en) begin
         sum_in = sum_upd;
         hwm_in = (pos_inc > hwm_ff) ? pos_inc : hwm_ff;
         if (CW'(pos_inc) >= CW'(len_ff)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FR_IDLE;
         primed_ff <= 1'b0;
         pos_ff    <= '0;
         hwm_ff    <= '0;
         sum_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         primed_ff <= primed_in;
         pos_ff    <= pos_in;
         hwm_ff    <= hwm_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= s_new;
         len_ff    <= len_eff;
         if (!primed_ff) begin
            fill_ff <= fill_new;
         end
      end
   end

   // History store: read the oldest entry on accept, overwrite it on update
   always_ff @(posedge clock) begin
      if (wr_en) begin
         history[pos_ff] <= sample_ff;
      end
      if (accept) begin
         old_ff <= history[pos_ff];
      end
   end

endmodule

// ===== design/mavg_queue.sv =====
module mavg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_push,
   input  mavg_pkg::entry_type wr_entry,
   output logic                wr_full,
   input  logic                rd_pop,
   output mavg_pkg::entry_type rd_entry,
   output logic                rd_empty
);
   import mavg_pkg::*;

   entry_type                 slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign wr_full  = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign rd_empty = (count_ff == '0);
   assign rd_entry = slots[rd_ptr_ff];
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== design/mavg_back.sv =====
module mavg_back #(
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mavg_pkg::entry_type            q_entry,
   input  logic                           q_empty,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [mavg_pkg::DATA_BITS-1:0] rsp_average
);
   import mavg_pkg::*;

   localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAT_LO = -SAT_HI - 64'sd1;
   localparam logic signed [SUM_BITS:0] SAT_HI_W = (SUM_BITS + 1)'(SAT_HI);
   localparam logic signed [SUM_BITS:0] SAT_LO_W = (SUM_BITS + 1)'(SAT_LO);

   back_state_type state_ff, state_in;

   logic                    neg_ff;
   logic [SUM_BITS-1:0]     quot_ff;
   logic [LEN_BITS-1:0]     rem_ff;
   logic [LEN_BITS-1:0]     div_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DATA_BITS-1:0]    avg_ff;
   logic                    valid_ff, valid_in;

   logic                    load_div;
   logic                    step_en;
   logic                    load_out;
   logic                    last_step;
   logic [SUM_BITS-1:0]     mag;
   logic [LEN_BITS:0]       r;
   logic [SUM_BITS-1:0]     dq;
   logic [LEN_BITS-1:0]     rem_step;
   logic [SUM_BITS-1:0]     quot_step;
   logic signed [SUM_BITS:0] q_signed;
   logic signed [SUM_BITS:0] q_sat;

   assign last_step = (cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1));

   // Next state
   always_comb begin
      case (state_ff)
         BK_IDLE:   state_in = q_empty ? BK_IDLE : BK_DIV;
         BK_DIV:    state_in = last_step ? BK_FINISH : BK_DIV;
         BK_FINISH: state_in = (!valid_ff || rsp_pop) ? BK_IDLE : BK_FINISH;
         default:   state_in = BK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      load_div = 1'b0;
      step_en  = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE:   load_div = !q_empty;
         BK_DIV:    step_en  = 1'b1;
         BK_FINISH: load_out = !valid_ff || rsp_pop;
         default:   load_div = 1'b0;
      endcase
   end

   assign q_pop = load_div;

   // Divide the magnitude, fix the sign afterwards
   assign mag = q_entry.sum[SUM_BITS-1] ? SUM_BITS'(-q_entry.sum) : SUM_BITS'(q_entry.sum);

   // Restoring division, DIV_STEPS quotient bits per cycle
   always_comb begin
      r  = {1'b0, rem_ff};
      dq = quot_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r  = {r[LEN_BITS-1:0], dq[SUM_BITS-1]};
         dq = {dq[SUM_BITS-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r     = r - {1'b0, div_ff};
            dq[0] = 1'b1;
         end
      end
      rem_step  = r[LEN_BITS-1:0];
      quot_step = dq;
   end

   // Restore sign and saturate to the sample range
   always_comb begin
      q_signed = neg_ff ? -signed'({1'b0, quot_ff}) : signed'({1'b0, quot_ff});
      if (q_signed > SAT_HI_W) begin
         q_sat = SAT_HI_W;
      end else if (q_signed < SAT_LO_W) begin
         q_sat = SAT_LO_W;
      end else begin
         q_sat = q_signed;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (load_div) begin
         cnt_in = '0;
      end else if (step_en) begin
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
      end
      valid_in = valid_ff;
      if (load_out) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_div) begin
         neg_ff  <= q_entry.sum[SUM_BITS-1];
         quot_ff <= mag;
         rem_ff  <= '0;
         div_ff  <= q_entry.len;
      end else if (step_en) begin
         quot_ff <= quot_step;
         rem_ff  <= rem_step;
      end
      if (load_out) begin
         avg_ff <= DATA_BITS'(q_sat);
      end
   end

   assign rsp_empty   = !valid_ff;
   assign rsp_average = avg_ff;

endmodule

// ===== design/moving_average_filter.sv =====
// Boxcar moving average: each sample transfer yields one result on rsp_average.
// The back end divides one queued sum at a time in its iterative divider: a load step,
// division steps at 4 quotient bits each, then a sign/saturate step.
// Front end: history read, then update, per sample before the next, into a 2-deep queue.
// Reset (synchronous, active high) clears the window sum, write position, primed flag,
// queue and result valid flag, and loads window_length = 1, initial_value = 0, fill_with_first = 0.
module moving_average_filter #(
   parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               push,
   output logic                               full,
   input  logic [mavg_pkg::DATA_BITS-1:0]     req_sample,
   // result channel
   output logic                               empty,
   input  logic                               pop,
   output logic [mavg_pkg::DATA_BITS-1:0]     rsp_average,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mavg_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mavg_pkg::DATA_BITS-1:0]     pwdata,
   output logic [mavg_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);
   import mavg_pkg::*;

   // Configuration registers
   logic [LEN_BITS-1:0]  window_length_ff, window_length_in;
   logic [DATA_BITS-1:0] initial_value_ff, initial_value_in;
   logic                 fill_with_first_ff, fill_with_first_in;

   logic          csr_write;
   reg_index_type csr_index;

   // Front to queue, queue to back
   entry_type front_entry;
   logic      front_push;
   logic      queue_full;
   entry_type back_entry;
   logic      back_pop;
   logic      queue_empty;

   // The register port never waits; a write lands on the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   // Decode writes; an address beyond the register list is dropped
   always_comb begin
      window_length_in   = window_length_ff;
      initial_value_in   = initial_value_ff;
      fill_with_first_in = fill_with_first_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WINDOW_LENGTH:   window_length_in   = pwdata[LEN_BITS-1:0];
            REG_INITIAL_VALUE:   initial_value_in   = pwdata;
            REG_FILL_WITH_FIRST: fill_with_first_in = pwdata[0];
            default:             window_length_in   = window_length_ff;
         endcase
      end
   end

   // Read back the stored register values
   always_comb begin
      case (csr_index)
         REG_WINDOW_LENGTH:   prdata = DATA_BITS'(window_length_ff);
         REG_INITIAL_VALUE:   prdata = initial_value_ff;
         REG_FILL_WITH_FIRST: prdata = DATA_BITS'(fill_with_first_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= LEN_BITS'(1);
         initial_value_ff   <= '0;
         fill_with_first_ff <= 1'b0;
      end else begin
         window_length_ff   <= window_length_in;
         initial_value_ff   <= initial_value_in;
         fill_with_first_ff <= fill_with_first_in;
      end
   end

   // Front end: take the sample, prime the window on the first transfer,
   // swap the oldest history entry for the sample and update the running sum.
   mavg_front #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_sample      (req_sample),
      .window_length   (window_length_ff),
      .initial_value   (initial_value_ff),
      .fill_with_first (fill_with_first_ff),
      .q_entry         (front_entry),
      .q_push          (front_push),
      .q_full          (queue_full)
   );

   // Hold updated sums until the divider is free
   mavg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (front_push),
      .wr_entry (front_entry),
      .wr_full  (queue_full),
      .rd_pop   (back_pop),
      .rd_entry (back_entry),
      .rd_empty (queue_empty)
   );

   // Back end: divide sum by length toward zero, saturate, present the result
   mavg_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_entry     (back_entry),
      .q_empty     (queue_empty),
      .q_pop       (back_pop),
      .rsp_empty   (empty),
      .rsp_pop     (pop),
      .rsp_average (rsp_average)
   );

endmodule

// ===== bench/moving_average_filter_tb.sv =====
`timescale 1ns / 100ps

module moving_average_filter_tb;

   import mavg_pkg::*;

   localparam int WINDOW = WINDOW_MAX_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 244;

   localparam logic [DATA_BITS-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_BITS-1:0] SAMPLE_MIN = 32'h8000_0000;

   typedef enum int {
      MIX_UNIFORM,
      MIX_EXTREME,
      MIX_SMALL,
      MIX_LOW
   } sample_mix_type;

   // Mirror of the filter state; predicts each average and checks arrivals in order
   class average_board;
      logic [LEN_BITS-1:0]         window_length;
      logic signed [DATA_BITS-1:0] initial_value;
      logic                        fill_with_first;
      logic signed [DATA_BITS-1:0] history [WINDOW];
      logic signed [SUM_BITS-1:0]  window_sum;
      int                          write_position;
      bit                          primed;
      logic [DATA_BITS-1:0]        pending_averages [$];
      int                          averages_checked;
      int                          mismatches;

      function new();
         window_length    = LEN_BITS'(1);
         initial_value    = 0;
         fill_with_first  = 1'b0;
         window_sum       = '0;
         write_position   = 0;
         primed           = 1'b0;
         averages_checked = 0;
         mismatches       = 0;
      endfunction

      function logic [DATA_BITS-1:0] predict_average(logic signed [DATA_BITS-1:0] sample);
         logic signed [DATA_BITS-1:0] fill;
         int                          len;
         int                          pos;
         longint                      quotient;
         // zero acts as one, anything past the store depth as the depth
         len = (window_length == 0) ? 1 :
               ((window_length > WINDOW) ? WINDOW : int'(window_length));
         if (!primed) begin
            fill = fill_with_first ? sample : initial_value;
            foreach (history[i]) history[i] = fill;
            window_sum     = SUM_BITS'(longint'(fill) * len);
            write_position = 0;
            primed         = 1'b1;
         end
         pos = (write_position >= WINDOW) ? 0 : write_position;
         // drop the oldest entry, take the new one; the sum wraps at its width
         window_sum   = window_sum - history[pos] + sample;
         history[pos] = sample;
         quotient = longint'(window_sum) / len;
         if (quotient > longint'(signed'(SAMPLE_MAX))) quotient = longint'(signed'(SAMPLE_MAX));
         if (quotient < longint'(signed'(SAMPLE_MIN))) quotient = longint'(signed'(SAMPLE_MIN));
         write_position = (pos + 1 >= len) ? 0 : pos + 1;
         return quotient[DATA_BITS-1:0];
      endfunction

      function void note_sample(logic [DATA_BITS-1:0] sample);
         pending_averages.push_back(predict_average(sample));
      endfunction

      task report(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_average(logic [DATA_BITS-1:0] got);
         logic [DATA_BITS-1:0] expected;
         if (pending_averages.size() == 0) begin
            report($sformatf("average %h arrived with no sample outstanding", got));
         end else begin
            expected = pending_averages.pop_front();
            averages_checked++;
            if (got !== expected)
               report($sformatf("average %h, expected %h", got, expected));
         end
      endtask

      task check_drained();
         if (pending_averages.size() != 0)
            report($sformatf("%0d averages never arrived", pending_averages.size()));
      endtask
   endclass

   // Every input starts at a known value
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [DATA_BITS-1:0]      req_sample = '0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [DATA_BITS-1:0]      rsp_average;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [DATA_BITS-1:0]      pwdata = '0;
   logic [DATA_BITS-1:0]      prdata;
   logic                      pready;

   average_board board;
   int           samples_sent = 0;
   int           cycle_count = 0;
   bit           steady = 1'b0;   // set for stretches with no idling on either side

   moving_average_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_sample  (req_sample),
      .empty       (empty),
      .pop         (pop),
      .rsp_average (rsp_average),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Idle length: none while steady, else mostly none, often a few cycles, now and then a long stretch
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady) return 0;
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [DATA_BITS-1:0] random_sample(sample_mix_type mix);
      int pick;
      pick = $urandom_range(0, 9);
      case (mix)
         MIX_EXTREME: begin
            case (pick % 5)
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               3: return '1;
               default: return $urandom();
            endcase
         end
         MIX_SMALL: return DATA_BITS'($urandom_range(0, 400)) - 32'd200;
         MIX_LOW: return (pick < 8) ? SAMPLE_MIN : $urandom();
         default: return $urandom();
      endcase
   endfunction

   // Window lengths, weighted toward the edges: zero, one, full depth and past it
   function automatic logic [LEN_BITS-1:0] random_length();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return LEN_BITS'(1);
         2: return LEN_BITS'($urandom_range(2, 16));
         3: return LEN_BITS'(WINDOW - 1);
         4: return LEN_BITS'(WINDOW);
         5: return LEN_BITS'($urandom_range(WINDOW + 1, (1 << LEN_BITS) - 1));
         default: return LEN_BITS'($urandom_range(1, WINDOW));
      endcase
   endfunction

   // Present one sample, hold it until the transfer, then idle at random
   task automatic send_sample(input logic [DATA_BITS-1:0] value);
      int gap;
      req_sample <= value;
      push       <= 1'b1;
      do @(posedge clock); while (full);
      samples_sent++;
      gap = idle_cycles();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop push and hold off until every outstanding average has been checked
   task automatic wait_drained();
      push <= 1'b0;
      while (board.averages_checked < samples_sent) @(posedge clock);
   endtask

   // Setup phase, access phase, then idle; mirror the value after the write
   task automatic csr_write(input reg_index_type index, input logic [DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_WINDOW_LENGTH:   board.window_length   = value[LEN_BITS-1:0];
         REG_INITIAL_VALUE:   board.initial_value   = value;
         REG_FILL_WITH_FIRST: board.fill_with_first = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Note each sample transfer and check each result transfer at the edge it happens
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) board.note_sample(req_sample);
         if (pop && !empty) board.check_average(rsp_average);
      end
   end

   // Result side: pop in bursts with random stalls in between
   initial begin : result_sink
      int hold;
      @(posedge clock);
      forever begin
         hold = idle_cycles();
         if (hold > 0) begin
            pop <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Watchdog: a run this long means a handshake has hung
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      sample_mix_type mix;
      int             pick;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Prime at length one; the fill comes from the register or from the first sample
      pick = $urandom_range(0, 2);
      csr_write(REG_WINDOW_LENGTH, 1);
      csr_write(REG_INITIAL_VALUE, (pick == 0) ? SAMPLE_MAX : ((pick == 1) ? SAMPLE_MIN : '0));
      csr_write(REG_FILL_WITH_FIRST, $urandom_range(0, 1));
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);

      // Grow the window while running; the sum carries on without a rebuild
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, WINDOW);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample('1);
      send_sample(1);
      send_sample(32'h4000_0000);

      // Shrink to one; the stale sum drives the average out of range
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, 1);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);

      // Length zero acts as one
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, 0);
      send_sample(32'h1234_5678);
      send_sample(SAMPLE_MIN);

      // Length past the store depth acts as the depth
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, (1 << LEN_BITS) - 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);

      // Odd length, so the quotient truncates
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, 3);
      send_sample(5);
      send_sample(-7);
      send_sample(100);

      // Random phases: new settings only once the filter has drained
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         steady = (phase == 3);
         if (phase == 0) begin
            // full window of extremes walks the sum toward its wrap point
            csr_write(REG_WINDOW_LENGTH, WINDOW);
            mix = MIX_EXTREME;
         end else begin
            csr_write(REG_WINDOW_LENGTH, DATA_BITS'(random_length()));
            mix = sample_mix_type'($urandom_range(0, 3));
         end
         csr_write(REG_INITIAL_VALUE, $urandom());
         csr_write(REG_FILL_WITH_FIRST, $urandom_range(0, 1));
         for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(random_sample(mix));
      end

      // Drain, then leave room for any stray result before the verdict
      wait_drained();
      steady = 1'b0;
      repeat (40) @(posedge clock);
      board.check_drained();
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
